/* hdl/sstc_pkg.sv */
`timescale 1ns / 1ps
package sstc_pkg;
   localparam int COORD_BITS = 24;
   localparam int FRAC_BITS  = 12;
   localparam int TIME_BITS  = 32;
   localparam int TIME_FRAC  = TIME_BITS / 2;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int RAD_BITS   = COORD_BITS - 1;
   localparam int SEL_BITS   = 4;

   // multiply schedule: three terms each for d.d, v.v, v.d, then R^2, h^2, a*c
   localparam logic [SEL_BITS-1:0] MSEL_DD = 4'd0;
   localparam logic [SEL_BITS-1:0] MSEL_VV = 4'd3;
   localparam logic [SEL_BITS-1:0] MSEL_VD = 4'd6;
   localparam logic [SEL_BITS-1:0] MSEL_RR = 4'd9;
   localparam logic [SEL_BITS-1:0] MSEL_HH = 4'd10;
   localparam logic [SEL_BITS-1:0] MSEL_AC = 4'd11;

   localparam logic [1:0] STAT_TOUCH = 2'd0;
   localparam logic [1:0] STAT_HIT   = 2'd1;
   localparam logic [1:0] STAT_STILL = 2'd2;
   localparam logic [1:0] STAT_MISS  = 2'd3;

   typedef enum logic [2:0] {
      OP_NONE, OP_STORE, OP_LOAD, OP_MUL, OP_SQRT, OP_DIV, OP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type           op;
      logic [SEL_BITS-1:0] sel;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic touch;
      logic nomotion;
      logic miss;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_MUL_WAIT, ST_CHECK1, ST_CHECK2, ST_SQRT_WAIT, ST_DIV_WAIT
   } ctrl_state_type;
endpackage

/* hdl/sstc_datapath.sv */
`timescale 1ns / 1ps
module sstc_datapath import sstc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  dp_cmd_type                  cmd,
   output dp_status_type               stat,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic signed [COORD_BITS-1:0] req_vel_x,
   input  logic signed [COORD_BITS-1:0] req_vel_y,
   input  logic signed [COORD_BITS-1:0] req_vel_z,
   input  logic [RAD_BITS-1:0]         req_radius,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic signed [TIME_BITS-1:0] rsp_hit_time,
   output logic signed [63:0]          rsp_miss_discriminant
);

   logic signed [COORD_BITS-1:0] first_pos_ff [3];
   logic signed [COORD_BITS-1:0] first_vel_ff [3];
   logic [RAD_BITS-1:0]          first_rad_ff;
   logic signed [DIFF_BITS-1:0]  d_ff [3];
   logic signed [DIFF_BITS-1:0]  v_ff [3];
   logic [COORD_BITS-1:0]        rs_ff;
   logic [63:0]  dist_ff, a_ff, rr_ff, h_ff;
   logic [127:0] hh_ff, ac_ff;
   logic [127:0] ma_ff, mp_ff;
   logic [63:0]  mb_ff;
   logic         mneg_ff, mrun_ff;
   logic [SEL_BITS-1:0] msel_ff;
   logic [127:0] sq_q_ff;
   logic [66:0]  sq_rem_ff;
   logic [63:0]  sq_root_ff;
   logic [5:0]   sq_cnt_ff;
   logic         sq_run_ff;
   logic [127:0] dv_num_ff, dv_quo_ff;
   logic [63:0]  dv_rem_ff, nmag_ff;
   logic [6:0]   dv_cnt_ff;
   logic         dv_run_ff;
   logic         done_ff;
   logic         valid_ff;
   logic [1:0]   status_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic [63:0]  disc_ff;

   function automatic logic [63:0] mag(input logic signed [DIFF_BITS-1:0] x);
      logic signed [DIFF_BITS:0] e;
      e = (DIFF_BITS+1)'(x);
      if (e < 0) e = -e;
      return 64'(unsigned'(e));
   endfunction

   logic [63:0] hmag, c_val, op_a, op_b, nmag_in;
   logic        op_neg, hneg;
   logic [1:0]  k;
   logic [66:0] sq_rem_n, sq_trial;
   logic [64:0] dv_r2;
   logic [129:0] miss_m;
   logic [63:0]  miss_mag;
   logic [127:0] quo_i;
   logic [63:0]  tval;
   logic [63:0]  tmax;

   assign hneg  = h_ff[63];
   assign hmag  = hneg ? (64'd0 - h_ff) : h_ff;
   assign c_val = dist_ff - rr_ff;
   assign tmax  = (64'd1 << (TIME_BITS - 1)) - 64'd1;

   always_comb begin
      k      = 2'd0;
      op_a   = '0;
      op_b   = '0;
      op_neg = 1'b0;
      priority if (cmd.sel < MSEL_VV) begin
         k    = 2'(cmd.sel - MSEL_DD);
         op_a = mag(d_ff[k]);
         op_b = mag(d_ff[k]);
      end else if (cmd.sel < MSEL_VD) begin
         k    = 2'(cmd.sel - MSEL_VV);
         op_a = mag(v_ff[k]);
         op_b = mag(v_ff[k]);
      end else if (cmd.sel < MSEL_RR) begin
         k      = 2'(cmd.sel - MSEL_VD);
         op_a   = mag(v_ff[k]);
         op_b   = mag(d_ff[k]);
         op_neg = v_ff[k][DIFF_BITS-1] ^ d_ff[k][DIFF_BITS-1];
      end else if (cmd.sel == MSEL_RR) begin
         op_a = 64'(rs_ff);
         op_b = 64'(rs_ff);
      end else if (cmd.sel == MSEL_HH) begin
         op_a = hmag;
         op_b = hmag;
      end else begin
         op_a = a_ff;
         op_b = c_val;
      end
   end

   assign sq_rem_n = {sq_rem_ff[64:0], sq_q_ff[127:126]};
   assign sq_trial = {1'b0, sq_root_ff, 2'b01};
   assign dv_r2    = {dv_rem_ff, dv_num_ff[127]};
   assign nmag_in  = hneg ? (hmag - sq_root_ff) : (hmag + sq_root_ff);

   always_comb begin
      miss_m   = ({2'b00, ac_ff - hh_ff} << 2) + 130'((64'd1 << (2 * FRAC_BITS)) - 64'd1);
      miss_m   = miss_m >> (2 * FRAC_BITS);
      miss_mag = (miss_m > 130'(64'd1 << 63)) ? (64'd1 << 63) : miss_m[63:0];
      quo_i    = dv_quo_ff;
      tval     = '0;
      if (!hneg && nmag_ff != 64'd0) begin
         quo_i = dv_quo_ff + 128'(dv_rem_ff != 64'd0);
         tval  = (quo_i > 128'(tmax + 64'd1)) ? (tmax + 64'd1) : quo_i[63:0];
         tval  = 64'd0 - tval;
      end else begin
         tval  = (dv_quo_ff > 128'(tmax)) ? tmax : dv_quo_ff[63:0];
      end
   end

   always_ff @(posedge clock) begin
      done_ff  <= 1'b0;
      valid_ff <= 1'b0;
      unique case (cmd.op)
         OP_STORE: begin
            first_pos_ff[0] <= req_pos_x;
            first_pos_ff[1] <= req_pos_y;
            first_pos_ff[2] <= req_pos_z;
            first_vel_ff[0] <= req_vel_x;
            first_vel_ff[1] <= req_vel_y;
            first_vel_ff[2] <= req_vel_z;
            first_rad_ff    <= req_radius;
         end
         OP_LOAD: begin
            d_ff[0] <= DIFF_BITS'(req_pos_x) - DIFF_BITS'(first_pos_ff[0]);
            d_ff[1] <= DIFF_BITS'(req_pos_y) - DIFF_BITS'(first_pos_ff[1]);
            d_ff[2] <= DIFF_BITS'(req_pos_z) - DIFF_BITS'(first_pos_ff[2]);
            v_ff[0] <= DIFF_BITS'(req_vel_x) - DIFF_BITS'(first_vel_ff[0]);
            v_ff[1] <= DIFF_BITS'(req_vel_y) - DIFF_BITS'(first_vel_ff[1]);
            v_ff[2] <= DIFF_BITS'(req_vel_z) - DIFF_BITS'(first_vel_ff[2]);
            rs_ff   <= COORD_BITS'(first_rad_ff) + COORD_BITS'(req_radius);
            dist_ff <= '0;
            a_ff    <= '0;
            h_ff    <= '0;
         end
         OP_MUL: begin
            ma_ff   <= 128'(op_a);
            mb_ff   <= op_b;
            mp_ff   <= '0;
            mneg_ff <= op_neg;
            msel_ff <= cmd.sel;
         end
         OP_SQRT: begin
            sq_q_ff    <= hh_ff - ac_ff;
            sq_rem_ff  <= '0;
            sq_root_ff <= '0;
            sq_cnt_ff  <= '0;
         end
         OP_DIV: begin
            nmag_ff   <= nmag_in;
            dv_num_ff <= 128'(nmag_in) << TIME_FRAC;
            dv_rem_ff <= '0;
            dv_quo_ff <= '0;
            dv_cnt_ff <= '0;
         end
         OP_RESULT: begin
            valid_ff <= 1'b0;
            time_ff  <= '0;
            disc_ff  <= '0;
            priority if (stat.touch) begin
               status_ff <= STAT_TOUCH;
            end else if (stat.nomotion) begin
               status_ff <= STAT_STILL;
               time_ff   <= TIME_BITS'(64'd0 - (64'd1 << TIME_FRAC));
            end else if (stat.miss) begin
               status_ff <= STAT_MISS;
               disc_ff   <= 64'd0 - miss_mag;
            end else begin
               status_ff <= STAT_HIT;
               time_ff   <= tval[TIME_BITS-1:0];
            end
            valid_ff <= 1'b1;
         end
         default: ;
      endcase

      // shift-add multiplier, one multiplier bit a cycle
      if (mrun_ff) begin
         if (mb_ff == 64'd0) begin
            done_ff <= 1'b1;
            priority if (msel_ff < MSEL_VV) dist_ff <= dist_ff + mp_ff[63:0];
            else if (msel_ff < MSEL_VD) a_ff <= a_ff + mp_ff[63:0];
            else if (msel_ff < MSEL_RR)
               h_ff <= mneg_ff ? (h_ff - mp_ff[63:0]) : (h_ff + mp_ff[63:0]);
            else if (msel_ff == MSEL_RR) rr_ff <= mp_ff[63:0];
            else if (msel_ff == MSEL_HH) hh_ff <= mp_ff;
            else ac_ff <= mp_ff;
         end else begin
            if (mb_ff[0]) mp_ff <= mp_ff + ma_ff;
            ma_ff <= ma_ff << 1;
            mb_ff <= mb_ff >> 1;
         end
      end

      // restoring square root, two radicand bits a cycle
      if (sq_run_ff) begin
         sq_q_ff   <= sq_q_ff << 2;
         sq_cnt_ff <= sq_cnt_ff + 6'd1;
         if (sq_rem_n >= sq_trial) begin
            sq_rem_ff  <= sq_rem_n - sq_trial;
            sq_root_ff <= {sq_root_ff[62:0], 1'b1};
         end else begin
            sq_rem_ff  <= sq_rem_n;
            sq_root_ff <= {sq_root_ff[62:0], 1'b0};
         end
         if (sq_cnt_ff == 6'd63) done_ff <= 1'b1;
      end

      // restoring divider, one quotient bit a cycle
      if (dv_run_ff) begin
         dv_num_ff <= dv_num_ff << 1;
         dv_cnt_ff <= dv_cnt_ff + 7'd1;
         if (dv_r2 >= {1'b0, a_ff}) begin
            dv_rem_ff <= 64'(dv_r2 - {1'b0, a_ff});
            dv_quo_ff <= {dv_quo_ff[126:0], 1'b1};
         end else begin
            dv_rem_ff <= dv_r2[63:0];
            dv_quo_ff <= {dv_quo_ff[126:0], 1'b0};
         end
         if (dv_cnt_ff == 7'd127) done_ff <= 1'b1;
      end

      if (reset) begin
         first_pos_ff[0] <= '0;
         first_pos_ff[1] <= '0;
         first_pos_ff[2] <= '0;
         first_vel_ff[0] <= '0;
         first_vel_ff[1] <= '0;
         first_vel_ff[2] <= '0;
         first_rad_ff    <= '0;
         done_ff         <= 1'b0;
         valid_ff        <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mrun_ff   <= 1'b0;
         sq_run_ff <= 1'b0;
         dv_run_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_MUL) mrun_ff <= 1'b1;
         else if (mrun_ff && mb_ff == 64'd0) mrun_ff <= 1'b0;
         if (cmd.op == OP_SQRT) sq_run_ff <= 1'b1;
         else if (sq_cnt_ff == 6'd63) sq_run_ff <= 1'b0;
         if (cmd.op == OP_DIV) dv_run_ff <= 1'b1;
         else if (dv_cnt_ff == 7'd127) dv_run_ff <= 1'b0;
      end
   end

   assign stat.done     = done_ff;
   assign stat.touch    = dist_ff <= rr_ff;
   assign stat.nomotion = a_ff == 64'd0;
   assign stat.miss     = hh_ff < ac_ff;

   assign rsp_valid             = valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_hit_time          = signed'(time_ff);
   assign rsp_miss_discriminant = signed'(disc_ff);
endmodule

/* hdl/sstc_ctrl.sv */
`timescale 1ns / 1ps
module sstc_ctrl import sstc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_type,
   input  dp_status_type stat,
   output dp_cmd_type    cmd,
   output logic          busy
);

   ctrl_state_type      state_ff, state_in;
   logic [SEL_BITS-1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= MSEL_DD;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd.op   = OP_NONE;
      cmd.sel  = idx_ff;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (!req_type) begin
                  cmd.op = OP_STORE;
               end else begin
                  cmd.op   = OP_LOAD;
                  idx_in   = MSEL_DD;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (stat.done) begin
               priority if (idx_ff == MSEL_RR) state_in = ST_CHECK1;
               else if (idx_ff == MSEL_AC) state_in = ST_CHECK2;
               else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_CHECK1: begin
            if (stat.touch || stat.nomotion) begin
               cmd.op   = OP_RESULT;
               state_in = ST_IDLE;
            end else begin
               idx_in   = MSEL_HH;
               state_in = ST_MUL;
            end
         end
         ST_CHECK2: begin
            if (stat.miss) begin
               cmd.op   = OP_RESULT;
               state_in = ST_IDLE;
            end else begin
               cmd.op   = OP_SQRT;
               state_in = ST_SQRT_WAIT;
            end
         end
         ST_SQRT_WAIT: begin
            if (stat.done) begin
               cmd.op   = OP_DIV;
               state_in = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (stat.done) begin
               cmd.op   = OP_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

/* hdl/swept_sphere_collision_time.sv */
`timescale 1ns / 1ps
// channel   ports                                   handshake
// request   req_type, req_pos_*, req_vel_*, req_radius  start & !busy
// result    rsp_status, rsp_hit_time, rsp_miss_discriminant  rsp_valid, one cycle
//
// A first-sphere request only stores the sphere and gives no result.
// A second-sphere request runs ten shift-add multiplies and ends there on touch/no-motion;
// miss and hit add two more, a hit then a square root and a divide. rsp_valid rises
// in the same cycle that busy drops.
// Synchronous reset clears the stored first sphere and all control state.
// Results cannot be stalled; a new request is taken in the cycle rsp_valid shows.
module swept_sphere_collision_time import sstc_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_type,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic signed [COORD_BITS-1:0] req_vel_x,
   input  logic signed [COORD_BITS-1:0] req_vel_y,
   input  logic signed [COORD_BITS-1:0] req_vel_z,
   input  logic [RAD_BITS-1:0]          req_radius,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic signed [TIME_BITS-1:0]  rsp_hit_time,
   output logic signed [63:0]           rsp_miss_discriminant
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   sstc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   sstc_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_pos_x             (req_pos_x),
      .req_pos_y             (req_pos_y),
      .req_pos_z             (req_pos_z),
      .req_vel_x             (req_vel_x),
      .req_vel_y             (req_vel_y),
      .req_vel_z             (req_vel_z),
      .req_radius            (req_radius),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_hit_time          (rsp_hit_time),
      .rsp_miss_discriminant (rsp_miss_discriminant)
   );
endmodule

/* hdl/sstc_checker.sv */
`timescale 1ns / 1ps
module sstc_checker import sstc_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_type,
   input logic                         rsp_valid,
   input logic [1:0]                   rsp_status,
   input logic signed [TIME_BITS-1:0]  rsp_hit_time,
   input logic signed [63:0]           rsp_miss_discriminant
);

   a_second_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_type |=> busy)
      else $error("second-sphere request did not start work");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in flight");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_disc_only_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_MISS |-> rsp_miss_discriminant == 64'sd0)
      else $error("discriminant set outside a miss");

   a_miss_negative: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_MISS |-> rsp_miss_discriminant < 64'sd0 &&
                                              rsp_hit_time == '0)
      else $error("miss result malformed");
endmodule

bind swept_sphere_collision_time sstc_checker u_sstc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .req_type              (req_type),
   .rsp_valid             (rsp_valid),
   .rsp_status            (rsp_status),
   .rsp_hit_time          (rsp_hit_time),
   .rsp_miss_discriminant (rsp_miss_discriminant)
);
